### rtl/fswq_pkg.sv
package fswq_pkg;

   localparam int SLOTS = 32;
   localparam int ID_BITS = 8;
   localparam int SLOT_BITS = 5;
   localparam int COUNT_BITS = 6;
   localparam int OP_BITS = 2;
   localparam int STATUS_BITS = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_BITS-1:0] OP_ENQUEUE  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_WAKE_ONE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_WAKE_ALL = 2'd2;
   localparam logic [OP_BITS-1:0] OP_UNUSED   = 2'd3;

   localparam logic [STATUS_BITS-1:0] STAT_QUEUED  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_FULL    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_WOKEN   = 2'd2;
   localparam logic [STATUS_BITS-1:0] STAT_NOTHING = 2'd3;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic [ID_BITS-1:0] waiter_id;
   } cmd_type;

endpackage

### rtl/fswq_front.sv
module fswq_front
   import fswq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_BITS-1:0] req_op,
   input  logic [7:0]         req_waiter_id,
   output logic               cmd_valid,
   output cmd_type            cmd,
   input  logic               cmd_pop
);

   cmd_type                   queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      push;
   logic                      pop;
   cmd_type                   new_cmd;

   assign req_stall = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   // The unused operation code is taken and dropped without a result.
   assign push = req_valid && !req_stall && (req_op != OP_UNUSED);
   assign pop  = cmd_pop && cmd_valid;

   always_comb begin
      new_cmd.op        = req_op;
      new_cmd.waiter_id = req_waiter_id[ID_BITS-1:0];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### rtl/fswq_back.sv
module fswq_back
   import fswq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  cmd_type                cmd,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [7:0]             rsp_woken_id,
   output logic [4:0]             rsp_slot_index,
   output logic [5:0]             rsp_waiting_count,
   output logic                   rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FIND = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [OP_BITS-1:0]     op_ff, op_in;
   logic [ID_BITS-1:0]     id_ff, id_in;
   logic [SLOT_BITS-1:0]   idx_ff, idx_in;
   logic                   found_ff, found_in;
   logic [SLOTS-1:0]       active_ff, active_in;
   logic [COUNT_BITS-1:0]  occupancy_ff, occupancy_in;
   logic [ID_BITS-1:0]     thread_ff [SLOTS];
   logic                   thread_we;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]     rsp_id_ff, rsp_id_in;
   logic [SLOT_BITS-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [SLOTS-1:0]       search_vec;
   logic [SLOT_BITS-1:0]   enc_idx;
   logic                   enc_found;
   logic                   out_free;
   logic                   load;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_woken_id      = rsp_id_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_waiting_count = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;

   // Enqueue looks for the lowest free slot, the wake operations for the lowest busy one.
   assign search_vec = (op_ff == OP_ENQUEUE) ? ~active_ff : active_ff;

   always_comb begin
      enc_idx   = '0;
      enc_found = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (search_vec[i]) begin
            enc_idx   = SLOT_BITS'(i);
            enc_found = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      active_in     = active_ff;
      occupancy_in  = occupancy_ff;
      thread_we     = 1'b0;
      load          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               op_in    = cmd.op;
               id_in    = cmd.waiter_id;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            idx_in   = enc_idx;
            found_in = enc_found;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_id_in   = '0;
               rsp_slot_in = '0;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
               if (op_ff == OP_ENQUEUE) begin
                  if (found_ff) begin
                     thread_we         = 1'b1;
                     active_in[idx_ff] = 1'b1;
                     occupancy_in      = occupancy_ff + 1'b1;
                     rsp_status_in     = STAT_QUEUED;
                     rsp_slot_in       = idx_ff;
                  end else begin
                     rsp_status_in = STAT_FULL;
                  end
               end else if (found_ff) begin
                  active_in[idx_ff] = 1'b0;
                  occupancy_in      = occupancy_ff - 1'b1;
                  rsp_status_in     = STAT_WOKEN;
                  rsp_id_in         = thread_ff[idx_ff];
                  rsp_slot_in       = idx_ff;
                  if (op_ff == OP_WAKE_ALL && occupancy_ff != COUNT_BITS'(1)) begin
                     rsp_last_in = 1'b0;
                     state_in    = ST_FIND;
                  end
               end else begin
                  rsp_status_in = STAT_NOTHING;
               end
               rsp_count_in = occupancy_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         occupancy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         occupancy_ff <= occupancy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      if (thread_we) begin
         thread_ff[idx_ff] <= id_ff;
      end
   end

endmodule

### rtl/fixed_slot_wait_queue_top.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid, req_stall  req_op, req_waiter_id
// rsp_      out        rsp_valid, rsp_stall  rsp_status, rsp_woken_id, rsp_slot_index,
//                                            rsp_waiting_count, rsp_last
//
// An enqueue or wake-one passes through the queue pop, the slot search and the result
// register after its transfer; its result is held there while rsp_stall is high. A
// wake-all runs a priority search over the slot bits, then releases the slot, per thread.
// Reset clears every slot bit and the count.
// The command queue holds two items, so it takes up to two requests while a result is stalled.
module fixed_slot_wait_queue_top
   import fswq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_BITS-1:0]     req_op,
   input  logic [7:0]             req_waiter_id,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [7:0]             rsp_woken_id,
   output logic [4:0]             rsp_slot_index,
   output logic [5:0]             rsp_waiting_count,
   output logic                   rsp_last
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   fswq_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_waiter_id (req_waiter_id),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   fswq_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_woken_id      (rsp_woken_id),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_waiting_count (rsp_waiting_count),
      .rsp_last          (rsp_last)
   );

endmodule
